// File: hdl/drq_pkg.sv
// Shared constants and types for the deferred release queue.
package drq_pkg;

	// Store sizes and field widths
	localparam int SET_DEPTH    = 64;
	localparam int RETIRE_DEPTH = 64;
	localparam int ID_BITS      = 16;
	localparam int RES_ID_W     = 16;
	localparam int FUNC_W       = 2;
	localparam int DELAY_W      = 8;

	localparam int SET_AW = $clog2(SET_DEPTH);
	localparam int SET_CW = $clog2(SET_DEPTH + 1);
	localparam int RET_AW = $clog2(RETIRE_DEPTH);
	localparam int RET_CW = $clog2(RETIRE_DEPTH + 1);
	localparam int SCAN_W = (SET_CW > RET_CW) ? SET_CW : RET_CW;

	localparam logic [DELAY_W-1:0] DELAY_RESET = DELAY_W'(3);

	// Operation codes
	localparam logic [FUNC_W-1:0] FUNC_SYNC    = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_ADVANCE = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_QUERY   = 2'd2;
	localparam logic [FUNC_W-1:0] FUNC_CLEAR   = 2'd3;

	typedef logic [ID_BITS-1:0] id_t;

	// One retire list entry: remaining frames and the id
	typedef struct packed {
		logic [DELAY_W-1:0] frames;
		id_t                id;
	} retire_entry_t;

endpackage

// File: hdl/drq_in_if.sv
// Request channel of the deferred release queue.
interface drq_in_if import drq_pkg::*;;
	logic                valid;
	logic                ready;
	logic [FUNC_W-1:0]   func;
	logic [RES_ID_W-1:0] res_id;
	logic                last;

	modport source (output valid, output func, output res_id, output last, input ready);
	modport sink (input valid, input func, input res_id, input last, output ready);
endinterface

// File: hdl/drq_out_if.sv
// Result channel of the deferred release queue.
interface drq_out_if import drq_pkg::*;;
	logic              valid;
	logic              ready;
	logic              is_held;
	logic [SET_CW-1:0] pinned_count;
	logic [RET_CW-1:0] retiring_count;
	logic              overflow;

	modport source (output valid, output is_held, output pinned_count,
		output retiring_count, output overflow, input ready);
	modport sink (input valid, input is_held, input pinned_count,
		input retiring_count, input overflow, output ready);
endinterface

// File: hdl/deferred_release_queue.sv
// Deferred release queue: tracks pinned ids and retiring ids with frame countdowns.
//
// One request at a time; every request returns exactly one result. Every search runs
// through one scan counter that steps through the single-read-port id memories,
// one entry per cycle, so timing follows the store fill levels: a live id scans
// the live set, a last-marked live id adds a commit that scans the live set once
// per pinned id, a frame advance scans the retire list, a query scans the longer
// of the pinned set and the retire list, and a clear scans nothing. The request
// side reopens as soon as the result is registered, so a waiting result does not
// block the next request. No clearing pass is needed after reset. Commit swaps
// the two set memory banks instead of copying the live set.
module deferred_release_queue import drq_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [DELAY_W-1:0] cfg_wdata,
	drq_in_if.sink             req,
	drq_out_if.source          rsp
);

	localparam logic [2:0] ST_IDLE      = 3'd0;
	localparam logic [2:0] ST_ADD       = 3'd1;
	localparam logic [2:0] ST_CMT_OUT   = 3'd2;
	localparam logic [2:0] ST_CMT_LATCH = 3'd3;
	localparam logic [2:0] ST_CMT_IN    = 3'd4;
	localparam logic [2:0] ST_QRY       = 3'd5;
	localparam logic [2:0] ST_ADV       = 3'd6;
	localparam logic [2:0] ST_DONE      = 3'd7;

	logic [2:0]         state_q;
	id_t                id_q;
	id_t                cand_q;
	logic               last_q;
	logic [SCAN_W-1:0]  idx_q;
	logic [SCAN_W-1:0]  idx_s1;
	logic               rd_vld_s1;
	logic               found_q;
	logic [SET_CW-1:0]  pidx_q;
	logic [RET_CW-1:0]  kept_q;
	logic [SET_CW-1:0]  live_total_q;
	logic [SET_CW-1:0]  pinned_total_q;
	logic [RET_CW-1:0]  retire_total_q;
	logic               pin_sel_q;
	logic               overflow_q;
	logic [DELAY_W-1:0] delay_q;
	logic               held_q;

	logic               out_valid_q;
	logic               out_held_q;
	logic [SET_CW-1:0]  out_pinned_q;
	logic [RET_CW-1:0]  out_retiring_q;
	logic               out_overflow_q;

	// Memories: two set banks (pinned / live, swapped on commit) and the retire list
	id_t           set_mem0 [SET_DEPTH];
	id_t           set_mem1 [SET_DEPTH];
	retire_entry_t ret_mem [RETIRE_DEPTH];
	id_t           set_rd0_s1;
	id_t           set_rd1_s1;
	retire_entry_t ret_rd_s1;

	logic [SCAN_W-1:0] scan_n;
	logic              scanning;
	logic              issue;
	logic              scan_end;
	logic              hit;
	id_t               pin_rd;
	id_t               live_rd;
	logic [SET_AW-1:0] set_raddr;
	logic              set_we;
	logic              live_full;
	logic              ret_full;
	logic              cmt_miss;
	logic              ret_we_c;
	logic              adv_keep;
	logic              ret_we;
	logic [RET_AW-1:0] ret_waddr;
	retire_entry_t     ret_wdata;

	assign pin_rd  = pin_sel_q ? set_rd1_s1 : set_rd0_s1;
	assign live_rd = pin_sel_q ? set_rd0_s1 : set_rd1_s1;

	// Scan length for the active operation
	always_comb begin
		scan_n   = '0;
		scanning = 1'b0;
		unique case (state_q)
			ST_ADD, ST_CMT_IN: begin
				scan_n   = SCAN_W'(live_total_q);
				scanning = 1'b1;
			end
			ST_QRY: begin
				scan_n   = (SCAN_W'(pinned_total_q) > SCAN_W'(retire_total_q)) ?
					SCAN_W'(pinned_total_q) : SCAN_W'(retire_total_q);
				scanning = 1'b1;
			end
			ST_ADV: begin
				scan_n   = SCAN_W'(retire_total_q);
				scanning = 1'b1;
			end
			default: begin
				scan_n   = '0;
				scanning = 1'b0;
			end
		endcase
	end

	assign issue    = scanning && (idx_q < scan_n);
	assign scan_end = scanning && !issue && !rd_vld_s1;

	// Match on the entry returned from memory
	always_comb begin
		hit = 1'b0;
		unique case (state_q)
			ST_ADD:    hit = (live_rd == id_q);
			ST_CMT_IN: hit = (live_rd == cand_q);
			ST_QRY:    hit = ((idx_s1 < SCAN_W'(pinned_total_q)) && (pin_rd == id_q)) ||
				((idx_s1 < SCAN_W'(retire_total_q)) && (ret_rd_s1.id == id_q));
			default:   hit = 1'b0;
		endcase
	end

	// Write controls for the set banks and the retire list
	assign live_full = (live_total_q == SET_CW'(SET_DEPTH));
	assign ret_full  = (retire_total_q == RET_CW'(RETIRE_DEPTH));
	assign set_we    = (state_q == ST_ADD) && scan_end && (id_q != '0) && !found_q && !live_full;
	assign cmt_miss  = (state_q == ST_CMT_IN) && scan_end && !found_q;
	assign ret_we_c  = cmt_miss && !ret_full;
	assign adv_keep  = (state_q == ST_ADV) && rd_vld_s1 && (ret_rd_s1.frames > DELAY_W'(1));
	assign ret_we    = ret_we_c || adv_keep;
	assign set_raddr = (state_q == ST_CMT_OUT) ? pidx_q[SET_AW-1:0] : idx_q[SET_AW-1:0];

	always_comb begin
		if (adv_keep) begin
			ret_waddr        = kept_q[RET_AW-1:0];
			ret_wdata.frames = ret_rd_s1.frames - DELAY_W'(1);
			ret_wdata.id     = ret_rd_s1.id;
		end else begin
			ret_waddr        = retire_total_q[RET_AW-1:0];
			ret_wdata.frames = delay_q;
			ret_wdata.id     = cand_q;
		end
	end

	// Set banks: append to the live bank, read both at one address
	always_ff @(posedge clk) begin
		if (set_we) begin
			if (pin_sel_q) begin
				set_mem0[live_total_q[SET_AW-1:0]] <= id_q;
			end else begin
				set_mem1[live_total_q[SET_AW-1:0]] <= id_q;
			end
		end
		set_rd0_s1 <= set_mem0[set_raddr];
		set_rd1_s1 <= set_mem1[set_raddr];
	end

	// Retire list memory
	always_ff @(posedge clk) begin
		if (ret_we) begin
			ret_mem[ret_waddr] <= ret_wdata;
		end
		ret_rd_s1 <= ret_mem[idx_q[RET_AW-1:0]];
	end

	// Sequencer, counters and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			id_q           <= '0;
			cand_q         <= '0;
			last_q         <= 1'b0;
			idx_q          <= '0;
			idx_s1         <= '0;
			rd_vld_s1      <= 1'b0;
			found_q        <= 1'b0;
			pidx_q         <= '0;
			kept_q         <= '0;
			live_total_q   <= '0;
			pinned_total_q <= '0;
			retire_total_q <= '0;
			pin_sel_q      <= 1'b0;
			overflow_q     <= 1'b0;
			delay_q        <= DELAY_RESET;
			held_q         <= 1'b0;
			out_valid_q    <= 1'b0;
			out_held_q     <= 1'b0;
			out_pinned_q   <= '0;
			out_retiring_q <= '0;
			out_overflow_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				delay_q <= cfg_wdata;
			end
			// Result drained; the done state reloads the register itself
			if (out_valid_q && rsp.ready && (state_q != ST_DONE)) begin
				out_valid_q <= 1'b0;
			end

			// Scan pipeline
			rd_vld_s1 <= issue;
			idx_s1    <= idx_q;
			if (issue) begin
				idx_q <= idx_q + SCAN_W'(1);
			end
			if (rd_vld_s1 && hit) begin
				found_q <= 1'b1;
			end

			// Store updates
			if (set_we) begin
				live_total_q <= live_total_q + SET_CW'(1);
			end
			if ((state_q == ST_ADD) && scan_end && (id_q != '0) && !found_q && live_full) begin
				overflow_q <= 1'b1;
			end
			if (ret_we_c) begin
				retire_total_q <= retire_total_q + RET_CW'(1);
			end
			if (cmt_miss && ret_full) begin
				overflow_q <= 1'b1;
			end
			if (adv_keep) begin
				kept_q <= kept_q + RET_CW'(1);
			end

			unique case (state_q)
				ST_IDLE: begin
					if (req.valid && req.ready) begin
						id_q    <= req.res_id[ID_BITS-1:0];
						last_q  <= req.last;
						held_q  <= 1'b0;
						idx_q   <= '0;
						found_q <= 1'b0;
						kept_q  <= '0;
						unique case (req.func)
							FUNC_SYNC:    state_q <= ST_ADD;
							FUNC_ADVANCE: state_q <= ST_ADV;
							FUNC_QUERY:   state_q <= ST_QRY;
							FUNC_CLEAR: begin
								live_total_q   <= '0;
								pinned_total_q <= '0;
								retire_total_q <= '0;
								state_q        <= ST_DONE;
							end
							default: state_q <= ST_DONE;
						endcase
					end
				end
				ST_ADD: begin
					if (scan_end) begin
						pidx_q  <= '0;
						state_q <= last_q ? ST_CMT_OUT : ST_DONE;
					end
				end
				ST_CMT_OUT: begin
					if (pidx_q < pinned_total_q) begin
						state_q <= ST_CMT_LATCH;
					end else begin
						// Live set becomes the pinned set
						pin_sel_q      <= ~pin_sel_q;
						pinned_total_q <= live_total_q;
						live_total_q   <= '0;
						state_q        <= ST_DONE;
					end
				end
				ST_CMT_LATCH: begin
					cand_q  <= pin_rd;
					idx_q   <= '0;
					found_q <= 1'b0;
					state_q <= ST_CMT_IN;
				end
				ST_CMT_IN: begin
					if (scan_end) begin
						pidx_q  <= pidx_q + SET_CW'(1);
						state_q <= ST_CMT_OUT;
					end
				end
				ST_QRY: begin
					if (scan_end) begin
						held_q  <= found_q && (id_q != '0);
						state_q <= ST_DONE;
					end
				end
				ST_ADV: begin
					if (scan_end) begin
						retire_total_q <= kept_q;
						state_q        <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!out_valid_q || rsp.ready) begin
						out_valid_q    <= 1'b1;
						out_held_q     <= held_q;
						out_pinned_q   <= pinned_total_q;
						out_retiring_q <= retire_total_q;
						out_overflow_q <= overflow_q;
						state_q        <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign req.ready          = (state_q == ST_IDLE);
	assign rsp.valid          = out_valid_q;
	assign rsp.is_held        = out_held_q;
	assign rsp.pinned_count   = out_pinned_q;
	assign rsp.retiring_count = out_retiring_q;
	assign rsp.overflow       = out_overflow_q;

	// Checks
	a_live_bound: assert property (@(posedge clk) disable iff (!arst_n)
		live_total_q <= SET_CW'(SET_DEPTH))
		else $error("live count beyond set depth");

	a_ovf_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		overflow_q |=> overflow_q)
		else $error("overflow flag dropped");

	a_ret_grow: assert property (@(posedge clk) disable iff (!arst_n)
		(retire_total_q > $past(retire_total_q)) |-> ($past(state_q) == ST_CMT_IN))
		else $error("retire list grew outside a commit");

	a_adv_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ADV && rd_vld_s1) |-> (SCAN_W'(kept_q) <= idx_s1))
		else $error("compaction write index passed read index");

endmodule
